>>> rtl/deq_pkg.sv
`default_nettype none
// ============================================================================
// deq_pkg
// Shared types and constants for the double-ended queue: command codes,
// result status codes, controller states and the control/status bundles
// between controller and datapath.
// ============================================================================
package deq_pkg;

    localparam int DEQ_CAPACITY  = 16;
    localparam int DEQ_WORD_BITS = 32;

    // Fixed widths of the stream fields
    localparam int FUNC_BITS     = 3;
    localparam int PUSH_BITS     = 32;
    localparam int OUT_BITS      = 32;
    localparam int STATUS_BITS   = 2;
    localparam int S_TDATA_BITS  = 40;  // func + push_word = 35, padded to bytes
    localparam int M_TDATA_BITS  = 32;

    // Command codes carried in the input transaction
    typedef enum logic [FUNC_BITS-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5,
        FN_CLEAR      = 3'd6
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_WORD  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    write_en;     // store push word at one end
        logic    read_en;      // read the word at one end
        logic    at_front;     // end selected by write_en / read_en
        logic    remove;       // read also removes the word
        logic    clear;        // empty the queue
        logic    load_status;  // load result register with status, zero word
        logic    load_word;    // load result register with read data
        status_t status;       // status for load_status
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic out_busy;        // result register holds an untaken result
    } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/deq_ctrl.sv
`default_nettype none
// ============================================================================
// deq_ctrl
// Command decoder and sequencer. Accepts one command at a time, issues
// datapath commands and waits in S_READ for the memory read of pops/peeks.
// ============================================================================
module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [FUNC_BITS-1:0] func,
    input  wire logic                 out_ready,
    input  wire dp_stat_t             stat,
    output dp_cmd_t                   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        in_ready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // result register free now or drained at this edge
                in_ready = !stat.out_busy || out_ready;
                accept   = in_valid && in_ready;
                if (accept)
                begin
                    case (func_t'(func))
                        FN_PUSH_FRONT, FN_PUSH_BACK:
                        begin
                            cmd.load_status = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.write_en = 1'b1;
                                cmd.at_front = (func_t'(func) == FN_PUSH_FRONT);
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_status = 1'b1;
                                cmd.status      = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.read_en  = 1'b1;
                                cmd.at_front = (func_t'(func) == FN_POP_FRONT) ||
                                               (func_t'(func) == FN_PEEK_FRONT);
                                cmd.remove   = (func_t'(func) == FN_POP_FRONT) ||
                                               (func_t'(func) == FN_POP_BACK);
                                state_next   = S_READ;
                            end
                        end
                        FN_CLEAR:
                        begin
                            cmd.clear       = 1'b1;
                            cmd.load_status = 1'b1;
                        end
                        default:
                        begin
                            // unused code: no state change, ok result
                            cmd.load_status = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // read data is registered now
                cmd.load_word = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/deq_datapath.sv
`default_nettype none
// ============================================================================
// deq_datapath
// Ring storage with front index and element count, end-address arithmetic
// and the result register of the output stream.
// ============================================================================
module deq_datapath
    import deq_pkg::*;
#(
    parameter int CAPACITY  = DEQ_CAPACITY,
    parameter int WORD_BITS = DEQ_WORD_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    input  wire logic [PUSH_BITS-1:0] push_word,
    input  wire logic                 out_ready,
    output dp_stat_t                  stat,
    output logic                      out_valid,
    output logic [STATUS_BITS-1:0]    out_status,
    output logic [OUT_BITS-1:0]       out_word
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

    logic [IDX_W-1:0]     first_reg, first_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [OUT_BITS-1:0]  word_reg, word_next;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WORD_BITS-1:0] mem [CAPACITY];

    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] last_sum;
    logic [IDX_W-1:0] tail_idx;   // slot after the back element
    logic [IDX_W-1:0] last_idx;   // slot of the back element
    logic [IDX_W-1:0] first_inc;
    logic [IDX_W-1:0] first_dec;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    // Ring address arithmetic: sums stay below twice the capacity
    always_comb
    begin
        tail_sum  = SUM_W'(first_reg) + SUM_W'(count_reg);
        last_sum  = tail_sum - SUM_W'(1);
        tail_idx  = (tail_sum >= CAP_SUM) ? IDX_W'(tail_sum - CAP_SUM) : IDX_W'(tail_sum);
        last_idx  = (last_sum >= CAP_SUM) ? IDX_W'(last_sum - CAP_SUM) : IDX_W'(last_sum);
        first_inc = (first_reg == LAST_IDX) ? '0 : first_reg + IDX_W'(1);
        first_dec = (first_reg == '0) ? LAST_IDX : first_reg - IDX_W'(1);
        wr_addr   = cmd.at_front ? first_dec : tail_idx;
        rd_addr   = cmd.at_front ? first_reg : last_idx;
    end

    // Front index and count update
    always_comb
    begin
        first_next = first_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            first_next = '0;
            count_next = '0;
        end
        else if (cmd.write_en)
        begin
            if (cmd.at_front)
            begin
                first_next = first_dec;
            end
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.read_en && cmd.remove)
        begin
            if (cmd.at_front)
            begin
                first_next = first_inc;
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Result register: load on command, drain on output transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        word_next      = word_reg;
        if (cmd.load_status)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.status;
            word_next      = '0;
        end
        else if (cmd.load_word)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_WORD;
            word_next      = OUT_BITS'(rd_data_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg     <= first_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        word_reg   <= word_next;
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_en)
        begin
            mem[wr_addr] <= WORD_BITS'(push_word);
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CAP_CNT);
    assign stat.out_busy = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_status    = status_reg;
    assign out_word      = word_reg;

endmodule
`default_nettype wire

>>> rtl/double_ended_queue.sv
`default_nettype none
// ============================================================================
// double_ended_queue
// Double-ended queue of words in a circular buffer with push, pop and peek
// at either end and a one-step clear.
// ============================================================================
// One command is taken per input transaction and answered by exactly one
// output transaction. Pushes, clear, unused codes and refused or empty-error
// commands load their result on acceptance; pops and peeks go through the
// read state, as the word comes from the ring memory's registered read port.
// A result register sits on the output, so the next command is taken while
// a result still waits as long as that result is taken in the same cycle.
// Slot contents are not cleared at reset; only live slots are ever read.
// ============================================================================
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY  = DEQ_CAPACITY,
    parameter int WORD_BITS = DEQ_WORD_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,   // func[2:0], push_word[34:3]
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0]      m_axis_tdata,   // out_word[31:0]
    output logic [STATUS_BITS-1:0]       m_axis_tuser    // status[1:0]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .func      (s_axis_tdata[FUNC_BITS-1:0]),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, pointers and result register
    deq_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_word  (s_axis_tdata[FUNC_BITS +: PUSH_BITS]),
        .out_ready  (m_axis_tready),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_word   (m_axis_tdata)
    );

    // A read blocks new commands until its word is loaded
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_en |=> (!s_axis_tready && cmd.load_word))
        else $error("read not followed by word load");

    // Never write into a full ring
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_en |-> !stat.full)
        else $error("write while full");

    // Full and empty exclusive (holds for a capacity of at least one)
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("full and empty together");

    // Only word results carry data
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_WORD)) |-> (m_axis_tdata == '0))
        else $error("nonzero word on status-only result");

endmodule
`default_nettype wire

>>> tb/double_ended_queue_test.sv
`default_nettype none
// ============================================================================
// double_ended_queue_test
// Self-checking testbench for the double-ended queue.
// ============================================================================
// Commands go in on the input stream. Each accepted command runs through a
// local deque model that keeps its own ring, head index and count. The
// expected status and word are queued, and each output transaction is
// compared with the oldest entry. A short table of directed commands comes
// first: empty errors, the all-ones word, the unused command code, filling
// to capacity, full refusals and clear. Random traffic follows in phases
// with different amounts of source idling and sink back-pressure. Random
// traffic alternates between fill-biased and drain-biased runs so that the
// queue often reaches full and empty. A long sink hold-off forces the block
// to stall its input.
// ============================================================================
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 7;
    localparam int PHASE_ITEMS = 256;
    localparam int HOLD_CYC    = 300;
    localparam int DRAIN_CYC   = 10;
    localparam int HEAD_BITS   = $clog2(DEQ_CAPACITY);
    localparam int CNT_BITS    = HEAD_BITS + 1;
    localparam int DIR_ROWS    = 12;

    // Command code with no operation behind it
    localparam logic [FUNC_BITS-1:0] FN_UNUSED = 3'd7;

    typedef struct packed {
        status_t                 st;
        logic [OUT_BITS-1:0]     word;
    } deque_result_t;

    // Directed row: command, push word, repeat count, typed-in result
    typedef struct packed {
        logic [FUNC_BITS-1:0]    fn;
        logic [PUSH_BITS-1:0]    word;
        logic [4:0]              reps;
        logic                    fixed;
        status_t                 st;
        logic [OUT_BITS-1:0]     rd;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [S_TDATA_BITS-1:0]     s_axis_tdata;    // func[2:0], push_word[34:3]
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [M_TDATA_BITS-1:0]     m_axis_tdata;    // out_word[31:0]
    logic [STATUS_BITS-1:0]      m_axis_tuser;    // status[1:0]

    // Local deque model state
    logic [DEQ_WORD_BITS-1:0]    ring_mem [DEQ_CAPACITY];
    logic [HEAD_BITS-1:0]        ring_head;
    logic [CNT_BITS-1:0]         ring_count;

    deque_result_t               expected_results [$];
    stim_row_t                   dir_table [DIR_ROWS];

    int                          error_count;
    int                          checked_count;
    int                          sent_count;
    int                          full_count;
    int                          empty_count;
    int                          clear_count;
    int                          idle_pct;
    int                          stall_pct;
    logic                        hold_armed;
    logic                        filling;

    double_ended_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Apply one command to the local deque and return its result
    task automatic deque_predict(input logic [FUNC_BITS-1:0] fn,
                                 input logic [PUSH_BITS-1:0] w,
                                 output status_t st,
                                 output logic [OUT_BITS-1:0] rd);
        logic [HEAD_BITS-1:0] pos;
        st = ST_OK;
        rd = '0;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (ring_count == DEQ_CAPACITY)
                begin
                    st = ST_FULL;
                    full_count++;
                end
                else
                begin
                    if (fn == FN_PUSH_FRONT)
                    begin
                        ring_head = ring_head - 1'b1;
                        pos = ring_head;
                    end
                    else
                        pos = ring_head + ring_count[HEAD_BITS-1:0];
                    ring_mem[pos] = w[DEQ_WORD_BITS-1:0];
                    ring_count++;
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
            begin
                if (ring_count == 0)
                begin
                    st = ST_EMPTY;
                    empty_count++;
                end
                else
                begin
                    if (fn == FN_POP_FRONT || fn == FN_PEEK_FRONT)
                        pos = ring_head;
                    else
                        pos = ring_head + ring_count[HEAD_BITS-1:0] - 1'b1;
                    rd = ring_mem[pos];
                    st = ST_WORD;
                    if (fn == FN_POP_FRONT)
                    begin
                        ring_head = ring_head + 1'b1;
                        ring_count--;
                    end
                    else if (fn == FN_POP_BACK)
                        ring_count--;
                end
            end
            FN_CLEAR:
            begin
                ring_head = '0;
                ring_count = '0;
                clear_count++;
            end
            default: ;
        endcase
    endtask

    // Offer one command, wait for acceptance, then queue its expected result
    task automatic send_cmd(input logic [FUNC_BITS-1:0] fn,
                            input logic [PUSH_BITS-1:0] w,
                            input logic fixed,
                            input status_t fixed_st,
                            input logic [OUT_BITS-1:0] fixed_rd);
        status_t              st;
        logic [OUT_BITS-1:0]  rd;
        deque_result_t        res;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_BITS - FUNC_BITS - PUSH_BITS){1'b0}}, w, fn};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        deque_predict(fn, w, st, rd);
        res.st   = fixed ? fixed_st : st;
        res.word = fixed ? fixed_rd : rd;
        expected_results.push_back(res);
        sent_count++;
    endtask

    // Random command, biased toward filling or draining the queue
    task automatic pick_random(output logic [FUNC_BITS-1:0] fn,
                               output logic [PUSH_BITS-1:0] w);
        int r;
        if (ring_count == 0)
            filling = 1'b1;
        else if (ring_count == DEQ_CAPACITY && $urandom_range(3) == 0)
            filling = 1'b0;
        else if ($urandom_range(40) == 0)
            filling = ~filling;
        r = $urandom_range(99);
        if (r < 3)
            fn = FN_CLEAR;
        else if (r < 5)
            fn = FN_UNUSED;
        else if (r < (filling ? 72 : 32))
            fn = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
        else
            fn = FUNC_BITS'($urandom_range(FN_PEEK_BACK, FN_POP_FRONT));
        case ($urandom_range(7))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom;
        endcase
    endtask

    // Sink: back-pressure, long hold-off and result checking
    initial
    begin
        deque_result_t exp_res;
        int            hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transaction: status %0d out_word %08h",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    checked_count++;
                    if (m_axis_tuser !== exp_res.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.st, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== exp_res.word)
                    begin
                        $error("out_word: expected %08h, got %08h",
                               exp_res.word, m_axis_tdata);
                        error_count++;
                    end
                end
            end
            if (hold_armed)
            begin
                hold_left = HOLD_CYC;
                hold_armed = 1'b0;
            end
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Run limit
    initial
    begin
        #(2 * CLK_HALF * 200000);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [FUNC_BITS-1:0] fn;
        logic [PUSH_BITS-1:0] w;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        ring_head     = '0;
        ring_count    = '0;
        error_count   = 0;
        checked_count = 0;
        sent_count    = 0;
        full_count    = 0;
        empty_count   = 0;
        clear_count   = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_armed    = 1'b0;
        filling       = 1'b1;

        dir_table = '{
            '{FN_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 32'h0000_0000},
            '{FN_PEEK_BACK,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 32'h0000_0000},
            '{FN_PUSH_FRONT, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,    32'h0000_0000},
            '{FN_PEEK_BACK,  32'h0000_0000, 5'd1,  1'b1, ST_WORD,  32'hFFFF_FFFF},
            '{FN_UNUSED,     32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,    32'h0000_0000},
            '{FN_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, ST_WORD,  32'hFFFF_FFFF},
            // fill to capacity from the back
            '{FN_PUSH_BACK,  32'h5A5A_0000, 5'd16, 1'b0, ST_OK,    32'h0000_0000},
            '{FN_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b1, ST_FULL,  32'h0000_0000},
            '{FN_PUSH_BACK,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_FULL,  32'h0000_0000},
            '{FN_POP_FRONT,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    32'h0000_0000},
            '{FN_CLEAR,      32'h0000_0000, 5'd1,  1'b1, ST_OK,    32'h0000_0000},
            '{FN_POP_BACK,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 32'h0000_0000}
        };

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_table[i])
            for (int k = 0; k < dir_table[i].reps; k++)
                send_cmd(dir_table[i].fn, dir_table[i].word ^ k,
                         dir_table[i].fixed, dir_table[i].st, dir_table[i].rd);

        // Random phases: none, source idle, sink stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            // source pauses until every result is back
            s_axis_tvalid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 14 : 0;
            stall_pct = (ph == 2) ? 56 : (ph == 3) ? 14 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 0 && n == 40)
                    hold_armed = 1'b1;
                pick_random(fn, w);
                send_cmd(fn, w, 1'b0, ST_OK, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;

        // Drain
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Sent %0d commands, checked %0d results.", sent_count, checked_count);
        $display("Full refusals %0d, empty errors %0d, clears %0d.",
                 full_count, empty_count, clear_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
